// ===== design/npt_pkg.sv =====
// ---------------------------------------------------------------------------
// npt_pkg: shared types and constants for the nearest point table
// Coordinates, transfer payloads, operation and status codes.
// ---------------------------------------------------------------------------
package npt_pkg;

    localparam int COORD_W       = 16;
    localparam int INDEX_W       = 9;
    localparam int STATUS_W      = 2;
    localparam int OP_W          = 2;
    localparam int SQ_W          = 32;
    localparam int DIST_W        = 34;
    localparam int DEPTH_DEFAULT = 512;

    localparam logic [DIST_W-1:0] LIMIT_RESET = 34'd2000000000;

    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXACT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0]  entry_index;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic equal;
    } t_dist_flags;

endpackage

// ===== design/npt_dist.sv =====
// ---------------------------------------------------------------------------
// npt_dist: distance stage of the table scan
// Squares the per-axis differences between a stored entry and the probe
// point into registers, flags an exact match, and presents the summed
// squared distance of the registered squares.
// ---------------------------------------------------------------------------
module npt_dist #(
    parameter int IDX_W = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [IDX_W-1:0]              i_idx,
    input  npt_pkg::t_point               i_entry,
    input  npt_pkg::t_point               i_pos,
    output npt_pkg::t_dist_flags          o_flags,
    output logic [IDX_W-1:0]              o_idx,
    output logic [npt_pkg::DIST_W-1:0]    o_dist
);
    import npt_pkg::*;

    localparam int PROD_W = 2*COORD_W + 2;

    logic signed [COORD_W:0]     dx, dy, dz;
    logic signed [PROD_W-1:0]    px, py, pz;

    logic              r_valid;
    logic              r_equal;
    logic [IDX_W-1:0]  r_idx;
    logic [SQ_W-1:0]   r_sx, r_sy, r_sz;

    always_comb begin
        dx = {i_pos.x[COORD_W-1], i_pos.x} - {i_entry.x[COORD_W-1], i_entry.x};
        dy = {i_pos.y[COORD_W-1], i_pos.y} - {i_entry.y[COORD_W-1], i_entry.y};
        dz = {i_pos.z[COORD_W-1], i_pos.z} - {i_entry.z[COORD_W-1], i_entry.z};
        px = PROD_W'(dx) * PROD_W'(dx);
        py = PROD_W'(dy) * PROD_W'(dy);
        pz = PROD_W'(dz) * PROD_W'(dz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // A difference is at most 65535 in magnitude, so each square fits 32 bits.
    always_ff @(posedge i_clk) begin
        r_idx   <= i_idx;
        r_equal <= (i_entry == i_pos);
        r_sx    <= px[SQ_W-1:0];
        r_sy    <= py[SQ_W-1:0];
        r_sz    <= pz[SQ_W-1:0];
    end

    assign o_flags.valid = r_valid;
    assign o_flags.equal = r_equal;
    assign o_idx         = r_idx;
    assign o_dist        = DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);

endmodule

// ===== design/nearest_point_table.sv =====
// ---------------------------------------------------------------------------
// nearest_point_table: table of 3D positions with nearest-match lookup
// One operation at a time: query nearest, insert position, clear table.
// ---------------------------------------------------------------------------
// Positions live in a single-port-read, single-port-write memory and every
// query, and every insert into a table that is not full, scans the stored
// entries 1 .. count-1 through its one read port, one entry per cycle. A
// clear, an insert into a full table and the unused code skip the scan.
// The input is stalled while an item is in progress; a finished result sits
// in an output register, so the next item can be taken while it waits.
// Entries are written only by inserts and only entries already written are
// read, so the memory needs no clearing after reset or on a clear.
// ---------------------------------------------------------------------------
module nearest_point_table #(
    parameter int TABLE_DEPTH = npt_pkg::DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  npt_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output npt_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [npt_pkg::DIST_W-1:0]    i_cfg_data
);
    import npt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] FULL_MARK = AW'(TABLE_DEPTH - 2);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    t_point r_mem [TABLE_DEPTH];

    logic [1:0]         r_state, n_state;
    logic [OP_W-1:0]    r_op, n_op;
    t_point             r_pos, n_pos;
    logic               r_full, n_full;
    logic [AW-1:0]      r_scan_idx, n_scan_idx;
    logic [AW-1:0]      r_next_slot, n_next_slot;
    logic [DIST_W-1:0]  r_best, n_best;
    logic               r_found, n_found;
    logic [AW-1:0]      r_found_idx, n_found_idx;
    logic [DIST_W-1:0]  r_limit;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item;

    logic               r_rd_valid;
    logic [AW-1:0]      r_rd_idx;
    t_point             r_rd_data;

    t_dist_flags        dist_flags;
    logic [AW-1:0]      dist_idx;
    logic [DIST_W-1:0]  dist_val;

    logic               in_take;
    logic               rd_issue;
    logic               out_load;
    logic               mem_we;
    t_out_item          res_item;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign rd_issue = (r_state == S_SCAN) && (r_scan_idx != r_next_slot);
    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    // A new entry goes in only when the scan found no equal position.
    assign mem_we   = out_load && (r_op == OP_INSERT) && !r_full && !r_found;

    // Memory: writes land only at the finish of an insert, while no read is
    // in flight, so a read never overlaps a write of the same entry.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_next_slot] <= r_pos;
        end
        r_rd_data <= r_mem[r_scan_idx];
        r_rd_idx  <= r_scan_idx;
    end

    npt_dist #(
        .IDX_W (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_idx   (r_rd_idx),
        .i_entry (r_rd_data),
        .i_pos   (r_pos),
        .o_flags (dist_flags),
        .o_idx   (dist_idx),
        .o_dist  (dist_val)
    );

    always_comb begin
        case (r_op)
            OP_QUERY: begin
                res_item.entry_index = r_found ? INDEX_W'(r_found_idx) : '0;
                res_item.status      = r_found ? ST_OK : ST_NONE;
            end
            OP_INSERT: begin
                if (r_full) begin
                    res_item.entry_index = '0;
                    res_item.status      = ST_FULL;
                end else if (r_found) begin
                    res_item.entry_index = INDEX_W'(r_found_idx);
                    res_item.status      = ST_EXACT;
                end else begin
                    res_item.entry_index = INDEX_W'(r_next_slot);
                    res_item.status      = ST_OK;
                end
            end
            OP_CLEAR: begin
                res_item.entry_index = '0;
                res_item.status      = ST_OK;
            end
            default: begin
                res_item.entry_index = '0;
                res_item.status      = ST_NONE;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_full      = r_full;
        n_scan_idx  = r_scan_idx;
        n_next_slot = r_next_slot;
        n_best      = r_best;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_out_valid = r_out_valid && i_out_stall;

        // Scan results: a query keeps the smallest distance below the limit, the
        // earliest entry winning a tie; an insert keeps the first exact match.
        if (dist_flags.valid) begin
            if (r_op == OP_QUERY) begin
                if (dist_val < r_best) begin
                    n_best      = dist_val;
                    n_found     = 1'b1;
                    n_found_idx = dist_idx;
                end
            end else if (dist_flags.equal && !r_found) begin
                n_found     = 1'b1;
                n_found_idx = dist_idx;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_op        = i_in_item.operation;
                    n_pos.x     = i_in_item.pos_x;
                    n_pos.y     = i_in_item.pos_y;
                    n_pos.z     = i_in_item.pos_z;
                    n_best      = r_limit;
                    n_found     = 1'b0;
                    n_found_idx = '0;
                    n_scan_idx  = AW'(1);
                    n_full      = (r_next_slot >= FULL_MARK);
                    case (i_in_item.operation)
                        OP_QUERY: begin
                            n_state = S_SCAN;
                        end
                        OP_INSERT: begin
                            n_state = (r_next_slot >= FULL_MARK) ? S_FIN : S_SCAN;
                        end
                        OP_CLEAR: begin
                            n_next_slot = AW'(1);
                            n_state     = S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_issue) begin
                    n_scan_idx = r_scan_idx + AW'(1);
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_valid && !dist_flags.valid) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (mem_we) begin
                        n_next_slot = r_next_slot + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_slot <= AW'(1);
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_slot <= n_next_slot;
            r_out_valid <= n_out_valid;
            r_rd_valid  <= rd_issue;
            r_found     <= n_found;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_full      <= n_full;
        r_scan_idx  <= n_scan_idx;
        r_best      <= n_best;
        r_found_idx <= n_found_idx;
        if (out_load) begin
            r_out_item <= res_item;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    // The fill count stays within the usable range of the table.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_slot != '0) && (r_next_slot <= FULL_MARK))
        else $error("fill count out of range");

    // Distance results only arrive while a scan is running or draining.
    a_dist_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_flags.valid |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("distance result outside a scan");

    // Every new entry written advances the fill count by exactly one.
    a_write_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_next_slot == $past(r_next_slot) + AW'(1)))
        else $error("insert did not advance the fill count");

    // A full report never carries an index.
    a_full_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_FULL)) |-> (o_out_item.entry_index == '0))
        else $error("full status with nonzero index");

    // A result is loaded only from the finish state with the input stalled.
    a_load_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (o_in_stall && !rd_issue && !r_rd_valid))
        else $error("result loaded while the scan was active");

endmodule
